### hw/rtl/bts_pkg.sv
package bts_pkg;

    localparam int FRAC_BITS_DEF = 8;
    localparam int MAX_WIDTH     = 256;
    localparam int MAX_HEIGHT    = 256;

    localparam int SIZE_W      = 9;
    localparam int COORD_W     = 17;
    localparam int ADDR_W      = 16;
    localparam int CH_W        = 8;
    localparam int TEXEL_W     = 3 * CH_W;
    localparam int FRAC_W      = 16;
    localparam int QUEUE_DEPTH = 4;
    localparam int CFG_IDX_W   = 1;

    localparam logic [CFG_IDX_W-1:0] REG_TEX_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_TEX_HEIGHT = 1'b1;
    localparam logic [SIZE_W-1:0]    SIZE_RESET     = 9'd256;

    typedef enum logic {
        REQ_LOAD   = 1'b0,
        REQ_SAMPLE = 1'b1
    } t_req;

    typedef struct packed {
        t_req                req;
        logic [ADDR_W-1:0]   index;
        logic [TEXEL_W-1:0]  texel;
        logic [SIZE_W-1:0]   x0;
        logic [SIZE_W-1:0]   x1;
        logic [SIZE_W-1:0]   y0;
        logic [SIZE_W-1:0]   y1;
        logic [FRAC_W-1:0]   fu;
        logic [FRAC_W-1:0]   fv;
    } t_job;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_stat;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_ROW,
        BK_TAP,
        BK_WAIT,
        BK_OUT
    } t_back_state;

endpackage

### hw/rtl/bts_front.sv
module bts_front #(
    parameter int FRAC_BITS = bts_pkg::FRAC_BITS_DEF
) (
    input  logic                          i_req_type,
    input  logic [bts_pkg::ADDR_W-1:0]    i_texel_index,
    input  logic [bts_pkg::CH_W-1:0]      i_texel_red,
    input  logic [bts_pkg::CH_W-1:0]      i_texel_green,
    input  logic [bts_pkg::CH_W-1:0]      i_texel_blue,
    input  logic [bts_pkg::COORD_W-1:0]   i_coord_u,
    input  logic [bts_pkg::COORD_W-1:0]   i_coord_v,
    input  logic [bts_pkg::SIZE_W-1:0]    i_width,
    input  logic [bts_pkg::SIZE_W-1:0]    i_height,
    output bts_pkg::t_job                 o_job
);

    localparam int SC_W  = bts_pkg::COORD_W + bts_pkg::SIZE_W;
    localparam int SPL_W = 2 * bts_pkg::SIZE_W + bts_pkg::FRAC_W;

    function automatic logic [SPL_W-1:0] split(
        input logic [bts_pkg::COORD_W-1:0] c,
        input logic [bts_pkg::SIZE_W-1:0]  size
    );
        logic [SC_W-1:0]              scaled;
        logic [SC_W-1:0]              top;
        logic [bts_pkg::SIZE_W-1:0]   lo;
        logic [bts_pkg::SIZE_W-1:0]   hi;
        logic [bts_pkg::FRAC_W-1:0]   frac;
        scaled = {{bts_pkg::SIZE_W{1'b0}}, c} * {{bts_pkg::COORD_W{1'b0}}, size};
        top    = {1'b0, size - bts_pkg::SIZE_W'(1), {bts_pkg::FRAC_W{1'b0}}};
        if (scaled > top) begin
            scaled = top;
        end
        lo   = scaled[bts_pkg::FRAC_W +: bts_pkg::SIZE_W];
        frac = scaled[bts_pkg::FRAC_W-1:0];
        hi   = (|frac[bts_pkg::FRAC_W-1 -: FRAC_BITS]) ? lo + bts_pkg::SIZE_W'(1) : lo;
        return {lo, hi, frac};
    endfunction

    logic [SPL_W-1:0] w_su;
    logic [SPL_W-1:0] w_sv;

    assign w_su = split(i_coord_u, i_width);
    assign w_sv = split(i_coord_v, i_height);

    always_comb begin
        o_job       = '0;
        o_job.req   = bts_pkg::t_req'(i_req_type);
        o_job.index = i_texel_index;
        o_job.texel = {i_texel_red, i_texel_green, i_texel_blue};
        {o_job.x0, o_job.x1, o_job.fu} = w_su;
        {o_job.y0, o_job.y1, o_job.fv} = w_sv;
    end

endmodule

### hw/rtl/bts_queue.sv
module bts_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  bts_pkg::t_job     i_job,
    input  logic              i_pop,
    output bts_pkg::t_job     o_job,
    output bts_pkg::t_q_stat  o_stat
);

    localparam int PTR_W = $clog2(bts_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(bts_pkg::QUEUE_DEPTH + 1);

    bts_pkg::t_job     r_slot [bts_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wr;
    logic [PTR_W-1:0]  r_rd;
    logic [CNT_W-1:0]  r_count;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(bts_pkg::QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= bump(r_wr);
            end
            if (i_pop) begin
                r_rd <= bump(r_rd);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr] <= i_job;
        end
    end

    assign o_job        = r_slot[r_rd];
    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == CNT_W'(bts_pkg::QUEUE_DEPTH));

endmodule

### hw/rtl/bts_back.sv
module bts_back #(
    parameter int FRAC_BITS = bts_pkg::FRAC_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  bts_pkg::t_job                i_job,
    input  bts_pkg::t_q_stat             i_stat,
    input  logic [bts_pkg::SIZE_W-1:0]   i_width,
    output logic                         o_pop,
    output logic                         o_valid,
    output logic [bts_pkg::CH_W-1:0]     o_red_out,
    output logic [bts_pkg::CH_W-1:0]     o_green_out,
    output logic [bts_pkg::CH_W-1:0]     o_blue_out
);

    localparam int ONE_W = FRAC_BITS + 1;
    localparam int WGT_W = 2 * ONE_W;
    localparam int ACC_W = WGT_W + bts_pkg::CH_W + 2;
    localparam int ROW_W = 2 * bts_pkg::SIZE_W;
    localparam int CH_W  = bts_pkg::CH_W;

    bts_pkg::t_back_state r_state;
    bts_pkg::t_back_state n_state;

    logic [1:0]                    r_tap;
    bts_pkg::t_job                 r_job;
    logic [ROW_W-1:0]              r_row0;
    logic [ROW_W-1:0]              r_row1;
    logic [bts_pkg::TEXEL_W-1:0]   r_rd;
    logic [WGT_W-1:0]              r_wgt;
    logic                          r_p1;
    logic [ACC_W-1:0]              r_acc_r;
    logic [ACC_W-1:0]              r_acc_g;
    logic [ACC_W-1:0]              r_acc_b;
    logic [bts_pkg::TEXEL_W-1:0]   r_mem [0:(2**bts_pkg::ADDR_W)-1];

    logic                          w_mem_we;
    logic                          w_take;
    logic                          w_tap_en;
    logic                          w_acc_clr;
    logic                          w_out_en;
    logic [FRAC_BITS-1:0]          w_s;
    logic [FRAC_BITS-1:0]          w_t;
    logic [ONE_W-1:0]              w_one;
    logic [ONE_W-1:0]              w_sw;
    logic [ONE_W-1:0]              w_tw;
    logic [WGT_W-1:0]              w_wgt;
    logic [bts_pkg::ADDR_W-1:0]    w_rd_addr;

    function automatic logic [CH_W-1:0] round_ch(input logic [ACC_W-1:0] acc);
        logic [ACC_W-1:0] sum;
        logic [ACC_W-1:0] q;
        sum = acc + (ACC_W'(1) << (2 * FRAC_BITS - 1));
        q   = sum >> (2 * FRAC_BITS);
        return (|q[ACC_W-1:CH_W]) ? {CH_W{1'b1}} : q[CH_W-1:0];
    endfunction

    function automatic logic [ACC_W-1:0] mac(
        input logic [ACC_W-1:0] acc,
        input logic [WGT_W-1:0] wgt,
        input logic [CH_W-1:0]  ch
    );
        return acc + ACC_W'(wgt) * ACC_W'(ch);
    endfunction

    assign w_s   = r_job.fu[bts_pkg::FRAC_W-1 -: FRAC_BITS];
    assign w_t   = r_job.fv[bts_pkg::FRAC_W-1 -: FRAC_BITS];
    assign w_one = {1'b1, {FRAC_BITS{1'b0}}};
    assign w_sw  = r_tap[0] ? {1'b0, w_s} : w_one - {1'b0, w_s};
    assign w_tw  = r_tap[1] ? {1'b0, w_t} : w_one - {1'b0, w_t};
    assign w_wgt = {{ONE_W{1'b0}}, w_sw} * {{ONE_W{1'b0}}, w_tw};
    assign w_rd_addr = bts_pkg::ADDR_W'((r_tap[1] ? r_row1 : r_row0)
                     + ROW_W'(r_tap[0] ? r_job.x1 : r_job.x0));

    always_comb begin
        n_state = r_state;
        case (r_state)
            bts_pkg::BK_IDLE: begin
                if (!i_stat.empty && i_job.req == bts_pkg::REQ_SAMPLE) begin
                    n_state = bts_pkg::BK_ROW;
                end
            end
            bts_pkg::BK_ROW: begin
                n_state = bts_pkg::BK_TAP;
            end
            bts_pkg::BK_TAP: begin
                if (r_tap == 2'd3) begin
                    n_state = bts_pkg::BK_WAIT;
                end
            end
            bts_pkg::BK_WAIT: begin
                n_state = bts_pkg::BK_OUT;
            end
            bts_pkg::BK_OUT: begin
                n_state = bts_pkg::BK_IDLE;
            end
            default: begin
                n_state = bts_pkg::BK_IDLE;
            end
        endcase
    end

    always_comb begin
        o_pop     = 1'b0;
        w_mem_we  = 1'b0;
        w_take    = 1'b0;
        w_tap_en  = 1'b0;
        w_acc_clr = 1'b0;
        w_out_en  = 1'b0;
        case (r_state)
            bts_pkg::BK_IDLE: begin
                o_pop    = !i_stat.empty;
                w_mem_we = !i_stat.empty && i_job.req == bts_pkg::REQ_LOAD;
                w_take   = !i_stat.empty && i_job.req == bts_pkg::REQ_SAMPLE;
            end
            bts_pkg::BK_ROW: begin
                w_acc_clr = 1'b1;
            end
            bts_pkg::BK_TAP: begin
                w_tap_en = 1'b1;
            end
            bts_pkg::BK_WAIT: begin
                w_out_en = 1'b0;
            end
            bts_pkg::BK_OUT: begin
                w_out_en = 1'b1;
            end
            default: begin
                o_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bts_pkg::BK_IDLE;
            r_tap   <= '0;
            r_p1    <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_tap   <= w_tap_en ? r_tap + 2'd1 : 2'd0;
            r_p1    <= w_tap_en;
            o_valid <= w_out_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_job <= i_job;
        end
        if (w_acc_clr) begin
            r_row0  <= {{bts_pkg::SIZE_W{1'b0}}, r_job.y0} * {{bts_pkg::SIZE_W{1'b0}}, i_width};
            r_row1  <= {{bts_pkg::SIZE_W{1'b0}}, r_job.y1} * {{bts_pkg::SIZE_W{1'b0}}, i_width};
            r_acc_r <= '0;
            r_acc_g <= '0;
            r_acc_b <= '0;
        end
        if (w_tap_en) begin
            r_wgt <= w_wgt;
        end
        if (r_p1) begin
            r_acc_r <= mac(r_acc_r, r_wgt, r_rd[2*CH_W +: CH_W]);
            r_acc_g <= mac(r_acc_g, r_wgt, r_rd[CH_W +: CH_W]);
            r_acc_b <= mac(r_acc_b, r_wgt, r_rd[0 +: CH_W]);
        end
        if (w_out_en) begin
            o_red_out   <= round_ch(r_acc_r);
            o_green_out <= round_ch(r_acc_g);
            o_blue_out  <= round_ch(r_acc_b);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[i_job.index] <= i_job.texel;
        end
        if (w_tap_en) begin
            r_rd <= r_mem[w_rd_addr];
        end
    end

    a_valid_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_state == bts_pkg::BK_OUT))
        else $error("Result strobe without a finished sample.");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> !i_stat.empty)
        else $error("Item taken from an empty queue.");

    a_tap_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bts_pkg::BK_TAP && r_tap == 2'd3) |=> (r_state == bts_pkg::BK_WAIT))
        else $error("Tap sequence did not end after four reads.");

    a_acc_after_tap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p1 |-> $past(r_state == bts_pkg::BK_TAP))
        else $error("Accumulate without a texel read.");

endmodule

### hw/rtl/bilinear_texture_sampler_unit.sv
// With the queue empty, an accepted sample is queued, popped in BK_IDLE and then stepped
// through BK_ROW, BK_TAP (four texel reads from one memory port), BK_WAIT and BK_OUT,
// after which o_valid is strobed; a 4-item queue lets the front accept one item per cycle until full.
// The receiver cannot stall; busy is high only while the queue is full.
// Reset is synchronous and active low: control state clears and both size registers return
// to 256; the texel store keeps no reset value.
module bilinear_texture_sampler_unit #(
    parameter int FRAC_BITS = bts_pkg::FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_req_type,
    input  logic [bts_pkg::ADDR_W-1:0]    i_texel_index,
    input  logic [bts_pkg::CH_W-1:0]      i_texel_red,
    input  logic [bts_pkg::CH_W-1:0]      i_texel_green,
    input  logic [bts_pkg::CH_W-1:0]      i_texel_blue,
    input  logic [bts_pkg::COORD_W-1:0]   i_coord_u,
    input  logic [bts_pkg::COORD_W-1:0]   i_coord_v,
    input  logic                          i_cfg_we,
    input  logic [bts_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [bts_pkg::SIZE_W-1:0]    i_cfg_data,
    output logic                          o_valid,
    output logic [bts_pkg::CH_W-1:0]      o_red_out,
    output logic [bts_pkg::CH_W-1:0]      o_green_out,
    output logic [bts_pkg::CH_W-1:0]      o_blue_out
);

    logic [bts_pkg::SIZE_W-1:0] r_tex_width;
    logic [bts_pkg::SIZE_W-1:0] r_tex_height;
    logic [bts_pkg::SIZE_W-1:0] w_eff_w;
    logic [bts_pkg::SIZE_W-1:0] w_eff_h;
    logic                       w_push;
    logic                       w_pop;
    bts_pkg::t_job              w_front_job;
    bts_pkg::t_job              w_q_job;
    bts_pkg::t_q_stat           w_q_stat;

    function automatic logic [bts_pkg::SIZE_W-1:0] eff_size(
        input logic [bts_pkg::SIZE_W-1:0] r,
        input int                         mx
    );
        if (r == '0) begin
            return bts_pkg::SIZE_W'(1);
        end
        if (int'(r) > mx) begin
            return bts_pkg::SIZE_W'(mx);
        end
        return r;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tex_width  <= bts_pkg::SIZE_RESET;
            r_tex_height <= bts_pkg::SIZE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                bts_pkg::REG_TEX_WIDTH: begin
                    r_tex_width <= i_cfg_data;
                end
                bts_pkg::REG_TEX_HEIGHT: begin
                    r_tex_height <= i_cfg_data;
                end
                default: begin
                    r_tex_width <= r_tex_width;
                end
            endcase
        end
    end

    assign w_eff_w = eff_size(r_tex_width, bts_pkg::MAX_WIDTH);
    assign w_eff_h = eff_size(r_tex_height, bts_pkg::MAX_HEIGHT);
    assign busy    = w_q_stat.full;
    assign w_push  = start && !busy;

    bts_front #(
        .FRAC_BITS(FRAC_BITS)
    ) u_front (
        .i_req_type    (i_req_type),
        .i_texel_index (i_texel_index),
        .i_texel_red   (i_texel_red),
        .i_texel_green (i_texel_green),
        .i_texel_blue  (i_texel_blue),
        .i_coord_u     (i_coord_u),
        .i_coord_v     (i_coord_v),
        .i_width       (w_eff_w),
        .i_height      (w_eff_h),
        .o_job         (w_front_job)
    );

    bts_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_front_job),
        .i_pop   (w_pop),
        .o_job   (w_q_job),
        .o_stat  (w_q_stat)
    );

    bts_back #(
        .FRAC_BITS(FRAC_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (w_q_job),
        .i_stat      (w_q_stat),
        .i_width     (w_eff_w),
        .o_pop       (w_pop),
        .o_valid     (o_valid),
        .o_red_out   (o_red_out),
        .o_green_out (o_green_out),
        .o_blue_out  (o_blue_out)
    );

endmodule
